// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the record delta codec RTL.
// Included by files that carry concurrent assertions; depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER_AT(label, clk, rst_n, cond, msg) \
  `ASSERT_AT(label, clk, rst_n, !(cond), msg)

`endif

// ===== hdl/rdc_pkg.sv =====
`timescale 1ns / 1ps
// Package of the record delta codec: transaction structs, codes and constants.
// Used by rdc_front, rdc_back, the top level and the testbench; depends on nothing.
package rdc_pkg;

  localparam int CmdW    = 2;
  localparam int IdxW    = 7;
  localparam int ByteW   = 8;
  localparam int CountW  = 17;
  localparam int KindW   = 3;

  localparam logic [ByteW-1:0]  EndBit    = 8'h80;
  localparam logic [ByteW-1:0]  EmptyMark = 8'hFF;
  localparam logic [IdxW-1:0]   OfsMask   = 7'h7F;
  localparam logic [CountW-1:0] BufReset  = 17'h10000;

  typedef enum logic [CmdW-1:0] {
    CMD_ENCODE = 2'd0,
    CMD_DECODE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [KindW-1:0] {
    KIND_RAW   = 3'd0,
    KIND_PAIR  = 3'd1,
    KIND_EMPTY = 3'd2,
    KIND_EVENT = 3'd3,
    KIND_READ  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    OP_ENCODE = 2'd0,
    OP_DECODE = 2'd1,
    OP_READ   = 2'd2
  } op_e;

  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [IdxW-1:0]  byte_index;
    logic [ByteW-1:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] header_byte;
    logic [ByteW-1:0] payload_byte;
    logic [IdxW-1:0]  record_offset;
    logic [ByteW-1:0] record_value;
    logic             wrote_byte;
    logic             frame_end;
    logic             last_result;
  } out_t;

  typedef struct packed {
    op_e              op;
    logic [IdxW-1:0]  byte_index;
    logic [ByteW-1:0] data_byte;
    logic             in_range;
    logic             is_last;
  } item_t;

  typedef struct packed {
    logic first_frame_done;
    logic pending_valid;
    logic await_payload;
  } status_t;

endpackage

// ===== hdl/rdc_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Stands alone; used for the record store.
module rdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/rdc_fifo.sv =====
`timescale 1ns / 1ps
// Small register queue between the codec front and back parts.
// Stands alone; carries packed transactions of any width.
module rdc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== hdl/rdc_front.sv =====
`timescale 1ns / 1ps
// Front part of the record delta codec: accepts input transactions and classifies them.
// Depends on rdc_pkg; feeds the item queue.
module rdc_front #(
  parameter int RECORD_BYTES = 64
) (
  input  logic          in_valid_i,
  input  rdc_pkg::in_t  in_data_i,
  output logic          in_stall_o,
  input  logic          q_full_i,
  output logic          push_o,
  output rdc_pkg::item_t item_o
);

  localparam logic [rdc_pkg::IdxW-1:0] RecBytesIdx = rdc_pkg::IdxW'(RECORD_BYTES);
  localparam logic [rdc_pkg::IdxW-1:0] LastIdx     = rdc_pkg::IdxW'(RECORD_BYTES - 1);

  logic in_range;
  logic keep;

  assign in_range   = (in_data_i.byte_index < RecBytesIdx);
  assign in_stall_o = q_full_i;

  always_comb begin
    keep           = 1'b0;
    item_o.op      = rdc_pkg::OP_READ;
    case (rdc_pkg::cmd_e'(in_data_i.cmd))
      rdc_pkg::CMD_ENCODE: begin
        item_o.op = rdc_pkg::OP_ENCODE;
        keep      = in_range;
      end
      rdc_pkg::CMD_DECODE: begin
        item_o.op = rdc_pkg::OP_DECODE;
        keep      = 1'b1;
      end
      rdc_pkg::CMD_READ: begin
        item_o.op = rdc_pkg::OP_READ;
        keep      = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
    item_o.byte_index = in_data_i.byte_index;
    item_o.data_byte  = in_data_i.data_byte;
    item_o.in_range   = in_range;
    item_o.is_last    = (in_data_i.byte_index == LastIdx);
  end

  assign push_o = in_valid_i && !q_full_i && keep;

endmodule

// ===== hdl/rdc_back.sv =====
`timescale 1ns / 1ps
// Back part of the record delta codec: record store, codec state and result queue.
// Depends on rdc_pkg and rdc_ram; takes items from the front queue.
module rdc_back #(
  parameter int RECORD_BYTES = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [rdc_pkg::CountW-1:0]   buffer_bytes_i,
  input  logic                         item_valid_i,
  input  rdc_pkg::item_t               item_i,
  output logic                         item_pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output rdc_pkg::out_t                out_data_o,
  output rdc_pkg::status_t             status_o
);

  localparam int AddrW = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
  localparam int CountW = rdc_pkg::CountW;
  localparam int IdxW = rdc_pkg::IdxW;
  localparam int ByteW = rdc_pkg::ByteW;
  localparam int OqDepth = 4;
  localparam int OqPtrW = $clog2(OqDepth);
  localparam int OqCntW = $clog2(OqDepth + 1);
  localparam logic [OqCntW-1:0] OqRoomTwo = OqCntW'(OqDepth - 2);
  localparam logic [CountW-1:0] RecBytes = CountW'(RECORD_BYTES);
  localparam logic [IdxW-1:0] RecBytesIdx = IdxW'(RECORD_BYTES);

  function automatic rdc_pkg::out_t mk_out(input rdc_pkg::kind_e kind,
                                           input logic [ByteW-1:0] hdr,
                                           input logic [ByteW-1:0] pay,
                                           input logic [IdxW-1:0] ofs,
                                           input logic [ByteW-1:0] val,
                                           input logic wrote,
                                           input logic fend);
    rdc_pkg::out_t r;
    r.kind          = kind;
    r.header_byte   = hdr;
    r.payload_byte  = pay;
    r.record_offset = ofs;
    r.record_value  = val;
    r.wrote_byte    = wrote;
    r.frame_end     = fend;
    r.last_result   = 1'b0;
    return r;
  endfunction

  logic                 exec_valid_q, exec_valid_d;
  rdc_pkg::item_t       cur_q;
  logic                 byp_hit_q;
  logic [ByteW-1:0]     byp_data_q;
  logic [CountW-1:0]    used_q, used_d;
  logic                 ffd_q, ffd_d;
  logic                 pv_q, pv_d;
  logic [IdxW-1:0]      pofs_q, pofs_d;
  logic [ByteW-1:0]     pval_q, pval_d;
  logic                 await_q, await_d;
  logic [ByteW-1:0]     hh_q, hh_d;

  rdc_pkg::out_t        oq_mem_q [OqDepth];
  logic [OqPtrW-1:0]    oq_wr_q, oq_rd_q;
  logic [OqCntW-1:0]    oq_cnt_q;

  logic                 exec_fire;
  logic                 out_pop;
  logic [ByteW-1:0]     ram_rdata;
  logic [ByteW-1:0]     rd_byte;
  logic                 wr_en;
  logic [AddrW-1:0]     wr_addr;
  logic [ByteW-1:0]     wr_data;
  rdc_pkg::out_t        res_a, res_b;
  logic [1:0]           n_res;
  logic [CountW:0]      used_p1, used_p2, used_p3, buf_ext;
  logic                 fit_pair, fit_mark, fit_mark_after;
  logic                 pv_n;
  logic [IdxW-1:0]      pofs_n, ofs7;
  logic [ByteW-1:0]     pval_n;
  logic                 mark_ok;
  logic                 fend;

  assign exec_fire  = exec_valid_q && (oq_cnt_q <= OqRoomTwo);
  assign item_pop_o = item_valid_i && (!exec_valid_q || exec_fire);
  assign rd_byte    = byp_hit_q ? byp_data_q : ram_rdata;

  assign buf_ext        = {1'b0, buffer_bytes_i};
  assign used_p1        = {1'b0, used_q} + (CountW + 1)'(1);
  assign used_p2        = {1'b0, used_q} + (CountW + 1)'(2);
  assign used_p3        = {1'b0, used_q} + (CountW + 1)'(3);
  assign fit_pair       = (used_p2 < buf_ext);
  assign fit_mark       = (used_p1 < buf_ext);
  assign fit_mark_after = (used_p3 < buf_ext);

  rdc_ram #(
    .WIDTH(ByteW),
    .DEPTH(RECORD_BYTES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (exec_fire && wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .re_i   (item_pop_o),
    .raddr_i(item_i.byte_index[AddrW-1:0]),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = cur_q.byte_index[AddrW-1:0];
    wr_data  = cur_q.data_byte;
    res_a    = '0;
    res_b    = '0;
    n_res    = 2'd0;
    used_d   = used_q;
    ffd_d    = ffd_q;
    pv_d     = pv_q;
    pofs_d   = pofs_q;
    pval_d   = pval_q;
    await_d  = await_q;
    hh_d     = hh_q;
    pv_n     = pv_q;
    pofs_n   = pofs_q;
    pval_n   = pval_q;
    mark_ok  = fit_mark;
    ofs7     = hh_q[IdxW-1:0] & rdc_pkg::OfsMask;
    fend     = 1'b0;
    case (cur_q.op)
      rdc_pkg::OP_ENCODE: begin
        if (!ffd_q) begin
          if (buffer_bytes_i >= RecBytes) begin
            wr_en = 1'b1;
            res_a = mk_out(rdc_pkg::KIND_RAW, cur_q.data_byte, '0, '0, '0, 1'b0, 1'b0);
            n_res = 2'd1;
            if (cur_q.is_last) begin
              used_d = RecBytes;
              ffd_d  = 1'b1;
            end
          end
        end else begin
          if (rd_byte != cur_q.data_byte) begin
            wr_en = 1'b1;
            if (fit_pair) begin
              if (pv_q) begin
                res_a = mk_out(rdc_pkg::KIND_PAIR, {1'b0, pofs_q}, pval_q, '0, '0,
                               1'b0, 1'b0);
                n_res = 2'd1;
              end
              pv_n    = 1'b1;
              pofs_n  = cur_q.byte_index;
              pval_n  = cur_q.data_byte;
              used_d  = used_p2[CountW-1:0];
              mark_ok = fit_mark_after;
            end
          end
          if (cur_q.is_last) begin
            if (pv_n) begin
              if (n_res == 2'd0) begin
                res_a = mk_out(rdc_pkg::KIND_PAIR, {1'b0, pofs_n} | rdc_pkg::EndBit, pval_n,
                               '0, '0, 1'b0, 1'b0);
              end else begin
                res_b = mk_out(rdc_pkg::KIND_PAIR, {1'b0, pofs_n} | rdc_pkg::EndBit, pval_n,
                               '0, '0, 1'b0, 1'b0);
              end
              n_res = n_res + 2'd1;
              pv_n  = 1'b0;
            end else if (mark_ok) begin
              res_a  = mk_out(rdc_pkg::KIND_EMPTY, rdc_pkg::EmptyMark, '0, '0, '0,
                              1'b0, 1'b0);
              n_res  = 2'd1;
              used_d = used_p1[CountW-1:0];
            end
          end
          pv_d   = pv_n;
          pofs_d = pofs_n;
          pval_d = pval_n;
        end
      end
      rdc_pkg::OP_DECODE: begin
        if (used_q < buffer_bytes_i) begin
          if (!ffd_q) begin
            if (buffer_bytes_i >= RecBytes && used_q < RecBytes) begin
              wr_en   = 1'b1;
              wr_addr = used_q[AddrW-1:0];
              used_d  = used_p1[CountW-1:0];
              fend    = (used_p1[CountW-1:0] == RecBytes);
              if (fend) begin
                ffd_d = 1'b1;
              end
              res_a = mk_out(rdc_pkg::KIND_EVENT, '0, '0, used_q[IdxW-1:0],
                             cur_q.data_byte, 1'b1, fend);
              n_res = 2'd1;
            end
          end else begin
            used_d = used_p1[CountW-1:0];
            if (await_q) begin
              await_d = 1'b0;
              n_res   = 2'd1;
              if (ofs7 < RecBytesIdx) begin
                wr_en   = 1'b1;
                wr_addr = ofs7[AddrW-1:0];
                res_a   = mk_out(rdc_pkg::KIND_EVENT, '0, '0, ofs7, cur_q.data_byte,
                                 1'b1, hh_q[ByteW-1]);
              end else begin
                res_a = mk_out(rdc_pkg::KIND_EVENT, '0, '0, '0, '0, 1'b0, hh_q[ByteW-1]);
              end
            end else if (cur_q.data_byte == rdc_pkg::EmptyMark) begin
              res_a = mk_out(rdc_pkg::KIND_EVENT, '0, '0, '0, '0, 1'b0, 1'b1);
              n_res = 2'd1;
            end else begin
              hh_d    = cur_q.data_byte;
              await_d = 1'b1;
            end
          end
        end
      end
      rdc_pkg::OP_READ: begin
        res_a = mk_out(rdc_pkg::KIND_READ, '0, '0, cur_q.byte_index,
                       cur_q.in_range ? rd_byte : '0, 1'b0, 1'b0);
        n_res = 2'd1;
      end
      default: begin
        n_res = 2'd0;
      end
    endcase
    if (n_res == 2'd1) begin
      res_a.last_result = 1'b1;
    end else if (n_res == 2'd2) begin
      res_b.last_result = 1'b1;
    end
  end

  always_comb begin
    exec_valid_d = exec_valid_q;
    if (item_pop_o) begin
      exec_valid_d = 1'b1;
    end else if (exec_fire) begin
      exec_valid_d = 1'b0;
    end
  end

  assign out_valid_o = (oq_cnt_q != '0);
  assign out_data_o  = oq_mem_q[oq_rd_q];
  assign out_pop     = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exec_valid_q <= 1'b0;
      used_q       <= '0;
      ffd_q        <= 1'b0;
      pv_q         <= 1'b0;
      pofs_q       <= '0;
      pval_q       <= '0;
      await_q      <= 1'b0;
      hh_q         <= '0;
      oq_wr_q      <= '0;
      oq_rd_q      <= '0;
      oq_cnt_q     <= '0;
    end else begin
      exec_valid_q <= exec_valid_d;
      if (exec_fire) begin
        used_q  <= used_d;
        ffd_q   <= ffd_d;
        pv_q    <= pv_d;
        pofs_q  <= pofs_d;
        pval_q  <= pval_d;
        await_q <= await_d;
        hh_q    <= hh_d;
        oq_wr_q <= oq_wr_q + OqPtrW'(n_res);
      end
      if (out_pop) begin
        oq_rd_q <= oq_rd_q + OqPtrW'(1);
      end
      oq_cnt_q <= oq_cnt_q + (exec_fire ? OqCntW'(n_res) : '0) - OqCntW'(out_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      cur_q      <= item_i;
      byp_hit_q  <= exec_fire && wr_en && (wr_addr == item_i.byte_index[AddrW-1:0]);
      byp_data_q <= wr_data;
    end
    if (exec_fire && n_res != 2'd0) begin
      oq_mem_q[oq_wr_q] <= res_a;
    end
    if (exec_fire && n_res == 2'd2) begin
      oq_mem_q[oq_wr_q + OqPtrW'(1)] <= res_b;
    end
  end

  assign status_o.first_frame_done = ffd_q;
  assign status_o.pending_valid    = pv_q;
  assign status_o.await_payload    = await_q;

endmodule

// ===== hdl/record_delta_codec_unit.sv =====
`timescale 1ns / 1ps
// Record delta codec top level: one transaction per cycle in unless in_stall_o is set,
// results one per cycle out unless out_stall_i is set. A transaction passes the input
// queue, the registered record store read and compare stage and the result queue; the
// single result port sends the results of a two-result transaction one after the other.
// Reset clears all control state at once; the record store is not cleared.
// Depends on rdc_pkg, rdc_front, rdc_fifo, rdc_back and assert_macros.svh.
`include "assert_macros.svh"
module record_delta_codec_unit #(
  parameter int RECORD_BYTES = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  rdc_pkg::in_t               in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output rdc_pkg::out_t              out_data_o,
  input  logic                       cfg_we_i,
  input  logic [rdc_pkg::CountW-1:0] cfg_wdata_i
);

  localparam int ItemW = $bits(rdc_pkg::item_t);

  logic [rdc_pkg::CountW-1:0] buffer_bytes_q;
  logic                       q_full;
  logic                       q_push;
  logic                       q_valid;
  logic                       q_pop;
  rdc_pkg::item_t             front_item;
  rdc_pkg::item_t             back_item;
  logic [ItemW-1:0]           q_rdata;
  rdc_pkg::status_t           stat;
  logic                       ffd_now;
  logic                       pend_now;
  logic                       await_now;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buffer_bytes_q <= rdc_pkg::BufReset;
    end else if (cfg_we_i) begin
      buffer_bytes_q <= cfg_wdata_i;
    end
  end

  rdc_front #(
    .RECORD_BYTES(RECORD_BYTES)
  ) u_front (
    .in_valid_i(in_valid_i),
    .in_data_i (in_data_i),
    .in_stall_o(in_stall_o),
    .q_full_i  (q_full),
    .push_o    (q_push),
    .item_o    (front_item)
  );

  rdc_fifo #(
    .WIDTH(ItemW),
    .DEPTH(2)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (front_item),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (q_rdata)
  );

  assign back_item = rdc_pkg::item_t'(q_rdata);

  rdc_back #(
    .RECORD_BYTES(RECORD_BYTES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .buffer_bytes_i(buffer_bytes_q),
    .item_valid_i  (q_valid),
    .item_i        (back_item),
    .item_pop_o    (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o),
    .status_o      (stat)
  );

  assign ffd_now   = stat.first_frame_done;
  assign pend_now  = stat.pending_valid;
  assign await_now = stat.await_payload;

  `ASSERT_AT(a_ffd_sticky, clk_i, rst_ni, ffd_now |=> ffd_now, "first frame flag cleared")
  `ASSERT_NEVER_AT(a_pend_early, clk_i, rst_ni, pend_now && !ffd_now, "pair held in raw frame")
  `ASSERT_NEVER_AT(a_await_early, clk_i, rst_ni, await_now && !ffd_now, "header held in raw frame")

endmodule

// ===== tb/rdc_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the record delta codec: watches both channels and the capacity port,
// predicts the results of every accepted transaction and compares them field by field.
// Depends on rdc_pkg only; the testbench top instantiates it beside the block.
module rdc_result_checker #(
  parameter int RECORD_BYTES = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  rdc_pkg::in_t               in_data_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  rdc_pkg::out_t              out_data_i,
  input  logic                       cfg_we_i,
  input  logic [rdc_pkg::CountW-1:0] cfg_wdata_i,
  output int                         fail_count_o,
  output int                         open_count_o,
  output logic [rdc_pkg::CountW-1:0] stream_used_o
);

  localparam int ByteW  = rdc_pkg::ByteW;
  localparam int IdxW   = rdc_pkg::IdxW;
  localparam int CountW = rdc_pkg::CountW;

  logic [ByteW-1:0]  record_image [RECORD_BYTES];
  logic [CountW-1:0] capacity;
  logic [CountW-1:0] stream_used;
  logic              raw_done;
  logic              pair_held;
  logic [IdxW-1:0]   pair_offset;
  logic [ByteW-1:0]  pair_value;
  logic              header_held;
  logic [ByteW-1:0]  held_header;
  rdc_pkg::out_t     awaited_results [$];
  rdc_pkg::out_t     new_results [2];
  int                new_count;

  function automatic string fmt_result(input rdc_pkg::out_t r);
    return $sformatf("kind=%0d hdr=%h pay=%h ofs=%0d val=%h wrote=%b fend=%b last=%b",
                     r.kind, r.header_byte, r.payload_byte, r.record_offset,
                     r.record_value, r.wrote_byte, r.frame_end, r.last_result);
  endfunction

  task automatic add_result(input rdc_pkg::kind_e kind, input logic [ByteW-1:0] hdr, pay,
                            input logic [IdxW-1:0] ofs, input logic [ByteW-1:0] val,
                            input logic wrote, fend);
    rdc_pkg::out_t r;
    r.kind          = kind;
    r.header_byte   = hdr;
    r.payload_byte  = pay;
    r.record_offset = ofs;
    r.record_value  = val;
    r.wrote_byte    = wrote;
    r.frame_end     = fend;
    r.last_result   = 1'b0;
    new_results[new_count] = r;
    new_count++;
  endtask

  task automatic compute_codec_results(input rdc_pkg::in_t item);
    logic [IdxW-1:0]  idx;
    logic [IdxW-1:0]  ofs;
    logic [ByteW-1:0] b;
    logic [ByteW-1:0] read_value;
    logic             fend;
    new_count = 0;
    idx = item.byte_index;
    b   = item.data_byte;
    case (item.cmd)
      rdc_pkg::CMD_ENCODE: begin
        if (int'(idx) < RECORD_BYTES) begin
          fend = (int'(idx) == RECORD_BYTES - 1);
          if (!raw_done) begin
            if (int'(capacity) >= RECORD_BYTES) begin
              record_image[idx] = b;
              add_result(rdc_pkg::KIND_RAW, b, '0, '0, '0, 1'b0, 1'b0);
              if (fend) begin
                stream_used = CountW'(RECORD_BYTES);
                raw_done    = 1'b1;
              end
            end
          end else begin
            if (record_image[idx] != b) begin
              record_image[idx] = b;
              if (int'(stream_used) + 2 < int'(capacity)) begin
                if (pair_held) begin
                  add_result(rdc_pkg::KIND_PAIR, {1'b0, pair_offset}, pair_value, '0, '0,
                             1'b0, 1'b0);
                end
                pair_held   = 1'b1;
                pair_offset = idx;
                pair_value  = b;
                stream_used = stream_used + CountW'(2);
              end
            end
            if (fend) begin
              if (pair_held) begin
                add_result(rdc_pkg::KIND_PAIR, rdc_pkg::EndBit | {1'b0, pair_offset},
                           pair_value, '0, '0, 1'b0, 1'b0);
                pair_held = 1'b0;
              end else if (int'(stream_used) + 1 < int'(capacity)) begin
                add_result(rdc_pkg::KIND_EMPTY, rdc_pkg::EmptyMark, '0, '0, '0, 1'b0, 1'b0);
                stream_used = stream_used + CountW'(1);
              end
            end
          end
        end
      end
      rdc_pkg::CMD_DECODE: begin
        if (int'(stream_used) < int'(capacity)) begin
          if (!raw_done) begin
            if (int'(capacity) >= RECORD_BYTES && int'(stream_used) < RECORD_BYTES) begin
              ofs  = stream_used[IdxW-1:0];
              fend = (int'(stream_used) + 1 == RECORD_BYTES);
              record_image[ofs] = b;
              add_result(rdc_pkg::KIND_EVENT, '0, '0, ofs, b, 1'b1, fend);
              stream_used = stream_used + CountW'(1);
              if (fend) begin
                raw_done = 1'b1;
              end
            end
          end else begin
            stream_used = stream_used + CountW'(1);
            if (header_held) begin
              ofs  = held_header[IdxW-1:0] & rdc_pkg::OfsMask;
              fend = ((held_header & rdc_pkg::EndBit) != '0);
              header_held = 1'b0;
              if (int'(ofs) < RECORD_BYTES) begin
                record_image[ofs] = b;
                add_result(rdc_pkg::KIND_EVENT, '0, '0, ofs, b, 1'b1, fend);
              end else begin
                add_result(rdc_pkg::KIND_EVENT, '0, '0, '0, '0, 1'b0, fend);
              end
            end else if (b == rdc_pkg::EmptyMark) begin
              add_result(rdc_pkg::KIND_EVENT, '0, '0, '0, '0, 1'b0, 1'b1);
            end else begin
              held_header = b;
              header_held = 1'b1;
            end
          end
        end
      end
      rdc_pkg::CMD_READ: begin
        read_value = (int'(idx) < RECORD_BYTES) ? record_image[idx] : '0;
        add_result(rdc_pkg::KIND_READ, '0, '0, idx, read_value, 1'b0, 1'b0);
      end
      default: begin
      end
    endcase
    if (new_count > 0) begin
      new_results[new_count-1].last_result = 1'b1;
    end
    for (int k = 0; k < new_count; k++) begin
      awaited_results.push_back(new_results[k]);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rdc_pkg::out_t want;
    rdc_pkg::out_t got;
    if (!rst_ni) begin
      capacity      = rdc_pkg::BufReset;
      stream_used   = '0;
      raw_done      = 1'b0;
      pair_held     = 1'b0;
      pair_offset   = '0;
      pair_value    = '0;
      header_held   = 1'b0;
      held_header   = '0;
      awaited_results.delete();
      fail_count_o  = 0;
      open_count_o  = 0;
      stream_used_o = '0;
    end else begin
      if (cfg_we_i) begin
        capacity = cfg_wdata_i;
      end
      if (in_valid_i && !in_stall_i) begin
        compute_codec_results(in_data_i);
      end
      if (out_valid_i && !out_stall_i) begin
        got = out_data_i;
        if (awaited_results.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) begin
            $display("%0t: result with none expected: %s", $time, fmt_result(got));
          end
        end else begin
          want = awaited_results.pop_front();
          if (got !== want) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("%0t: result mismatch, expected %s", $time, fmt_result(want));
              $display("%0t:                   actual %s", $time, fmt_result(got));
            end
          end
        end
      end
      open_count_o  = awaited_results.size();
      stream_used_o = stream_used;
    end
  end

endmodule

// ===== tb/tb_record_delta_codec_unit.sv =====
`timescale 1ns / 1ps
// Testbench top for record_delta_codec_unit: makes encode, decode and read transactions,
// capacity writes and back-pressure, and prints the verdict from the result checker.
// Depends on rdc_pkg, rdc_result_checker and the codec RTL.
module tb_record_delta_codec_unit;

  localparam int RecordBytes  = 64;
  localparam int CycleLimit   = 400000;
  localparam int SettleCycles = 8;
  localparam int HoldCycles   = 300;
  localparam int ByteW        = rdc_pkg::ByteW;
  localparam int IdxW         = rdc_pkg::IdxW;
  localparam int CountW       = rdc_pkg::CountW;

  typedef enum int {
    PACE_SLOW_SINK,
    PACE_SLOW_SOURCE,
    PACE_STEADY
  } pace_e;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  rdc_pkg::in_t      in_data_i;
  logic              out_valid_o;
  logic              out_stall_i;
  rdc_pkg::out_t     out_data_o;
  logic              cfg_we_i;
  logic [CountW-1:0] cfg_wdata_i;

  int                fail_count;
  int                open_count;
  logic [CountW-1:0] stream_used;

  pace_e             pace;
  logic              hold_request;
  int                hold_left;
  int                sent_count;
  int                cycle_count;
  logic [ByteW-1:0]  sent_image [RecordBytes];

  record_delta_codec_unit #(
    .RECORD_BYTES(RecordBytes)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  rdc_result_checker #(
    .RECORD_BYTES(RecordBytes)
  ) result_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fail_count_o (fail_count),
    .open_count_o (open_count),
    .stream_used_o(stream_used)
  );

  always #10 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_left    = HoldCycles;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (pace == PACE_SLOW_SINK) begin
      out_stall_i <= ($urandom_range(99) < 64);
    end else if (pace == PACE_SLOW_SOURCE) begin
      out_stall_i <= ($urandom_range(99) < 16);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic send_item(input rdc_pkg::cmd_e op, input logic [IdxW-1:0] idx,
                           input logic [ByteW-1:0] data);
    rdc_pkg::in_t item;
    int           gap;
    item.cmd        = op;
    item.byte_index = idx;
    item.data_byte  = data;
    gap = 0;
    if (pace == PACE_SLOW_SINK) begin
      while ($urandom_range(99) < 16) gap++;
    end else if (pace == PACE_SLOW_SOURCE) begin
      while ($urandom_range(99) < 64) gap++;
    end
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_count++;
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (open_count != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic set_capacity(input logic [CountW-1:0] value);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic encode_byte(input int idx, input logic [ByteW-1:0] value);
    send_item(rdc_pkg::CMD_ENCODE, IdxW'(idx), value);
    sent_image[idx] = value;
  endtask

  task automatic decode_pair(input logic [ByteW-1:0] header, payload);
    send_item(rdc_pkg::CMD_DECODE, IdxW'($urandom), header);
    send_item(rdc_pkg::CMD_DECODE, IdxW'($urandom), payload);
    if (header != rdc_pkg::EmptyMark && int'(header[IdxW-1:0]) < RecordBytes) begin
      sent_image[header[IdxW-1:0]] = payload;
    end
  endtask

  task automatic send_noise();
    case ($urandom_range(2))
      0: send_item(rdc_pkg::CMD_READ, IdxW'($urandom_range(126)), 8'($urandom));
      1: send_item(rdc_pkg::CMD_NONE, IdxW'($urandom), 8'($urandom));
      default: send_item(rdc_pkg::CMD_ENCODE, IdxW'($urandom_range(126, RecordBytes)),
                         8'($urandom));
    endcase
  endtask

  task automatic encode_frame(input int change_pct);
    int stop_at;
    stop_at = ($urandom_range(99) < 10) ? $urandom_range(RecordBytes - 2) : RecordBytes;
    for (int i = 0; i < stop_at; i++) begin
      if (i < RecordBytes - 1 && $urandom_range(99) < 5) continue;
      if ($urandom_range(99) < change_pct) begin
        encode_byte(i, 8'($urandom));
      end else begin
        encode_byte(i, sent_image[i]);
      end
      if ($urandom_range(99) < 3) send_noise();
    end
  endtask

  task automatic decode_burst(input int groups);
    logic [ByteW-1:0] header;
    for (int k = 0; k < groups; k++) begin
      if ($urandom_range(99) < 15) begin
        send_item(rdc_pkg::CMD_DECODE, IdxW'($urandom), rdc_pkg::EmptyMark);
      end else begin
        header[7] = 1'($urandom_range(1));
        header[IdxW-1:0] = ($urandom_range(99) < 90) ? IdxW'($urandom_range(RecordBytes - 1)) :
                                                      IdxW'($urandom_range(127, RecordBytes));
        if ($urandom_range(99) < 5) begin
          send_item(rdc_pkg::CMD_DECODE, IdxW'($urandom), header);
        end else begin
          decode_pair(header, 8'($urandom));
        end
      end
    end
  endtask

  task automatic run_random(input int item_goal);
    int target;
    int pick;
    target = sent_count + item_goal;
    while (sent_count < target) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        case ($urandom_range(3))
          0: encode_frame(0);
          1: encode_frame(4);
          2: encode_frame(15);
          default: encode_frame(100);
        endcase
      end else if (pick < 75) begin
        decode_burst($urandom_range(12, 1));
      end else if (pick < 88) begin
        repeat ($urandom_range(6, 1)) send_item(rdc_pkg::CMD_READ,
                                                IdxW'($urandom_range(126)), 8'($urandom));
      end else begin
        repeat ($urandom_range(3, 1)) send_noise();
      end
    end
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic [ByteW-1:0] value;
    int               raw_decodes;
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    out_stall_i  = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    pace         = PACE_SLOW_SINK;
    hold_request = 1'b0;
    hold_left    = 0;
    sent_count   = 0;
    raw_decodes  = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // With a capacity below one record the raw frame is neither coded nor stored.
    set_capacity(CountW'(RecordBytes - 1));
    send_item(rdc_pkg::CMD_ENCODE, '0, 8'h00);
    send_item(rdc_pkg::CMD_ENCODE, IdxW'(RecordBytes - 1), 8'hFF);
    send_item(rdc_pkg::CMD_DECODE, '0, 8'h12);
    send_item(rdc_pkg::CMD_READ, IdxW'(126), 8'h00);
    send_item(rdc_pkg::CMD_ENCODE, IdxW'(126), 8'h5A);
    send_item(rdc_pkg::CMD_NONE, IdxW'(127), 8'hFF);
    set_capacity('0);
    send_item(rdc_pkg::CMD_DECODE, '0, 8'hAB);

    // The raw frame writes every record byte, so later reads never see an unwritten one.
    set_capacity(rdc_pkg::BufReset);
    for (int i = 0; i < RecordBytes; i++) begin
      value = (i == 0) ? 8'h00 : (i == RecordBytes - 1) ? 8'hFF : 8'($urandom);
      encode_byte(i, value);
      if (i % 16 == 5) begin
        value = 8'($urandom);
        send_item(rdc_pkg::CMD_DECODE, IdxW'($urandom), value);
        sent_image[raw_decodes] = value;
        raw_decodes++;
      end
    end
    send_item(rdc_pkg::CMD_READ, '0, 8'h00);
    send_item(rdc_pkg::CMD_READ, IdxW'(RecordBytes - 1), 8'hFF);
    encode_byte(RecordBytes - 1, sent_image[RecordBytes - 1]);
    encode_byte(0, ~sent_image[0]);
    encode_byte(RecordBytes - 2, ~sent_image[RecordBytes - 2]);
    encode_byte(RecordBytes - 1, sent_image[RecordBytes - 1]);
    encode_byte(5, ~sent_image[5]);
    encode_byte(RecordBytes - 1, ~sent_image[RecordBytes - 1]);
    encode_byte(RecordBytes - 1, ~sent_image[RecordBytes - 1]);
    send_item(rdc_pkg::CMD_DECODE, '0, rdc_pkg::EmptyMark);
    decode_pair(rdc_pkg::EndBit | 8'h05, 8'h00);
    decode_pair(8'h03, 8'hFF);
    decode_pair(rdc_pkg::EndBit | 8'h48, 8'h55);
    decode_pair(8'h7F, 8'hAA);
    send_item(rdc_pkg::CMD_READ, IdxW'(5), 8'h00);
    send_item(rdc_pkg::CMD_READ, IdxW'(126), 8'h00);

    hold_request = 1'b1;
    run_random(60);
    settle();
    run_random(300);

    pace = PACE_SLOW_SOURCE;
    repeat (4) begin
      settle();
      set_capacity(CountW'(int'(stream_used) + $urandom_range(40, 2)));
      run_random(55);
    end
    set_capacity('0);
    run_random(30);

    set_capacity(rdc_pkg::BufReset);
    pace = PACE_STEADY;
    run_random(330);

    settle();
    if (fail_count == 0 && open_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
